@@ hdl/bdq_pkg.sv @@
// shared types, constants and ring helpers for the bounded deque
// depends on nothing; every other file refers to it by scoped names
package bdq_pkg;

    // ring size and the widths that follow from it
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // command queue between the front and the back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);
    localparam idx_t LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_VIEW       = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_PUSH_FRONT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic                     last;
    } rsp_t;

    // classified request as it sits in the command queue
    typedef struct packed {
        logic                     is_push;
        logic                     at_front;
        logic                     is_view;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    // what travels beside the memory read data
    typedef struct packed {
        logic    use_mem;
        status_t status;
        logic    last;
    } meta_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_VIEW = 1'b1
    } back_state_t;

    // base + off modulo DEPTH, with base < DEPTH and off < DEPTH
    function automatic idx_t ring_add(idx_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t ring_inc(idx_t base);
        idx_t res;
        if (base == LAST_IDX)
        begin
            res = '0;
        end
        else
        begin
            res = base + idx_t'(1);
        end
        return res;
    endfunction

    function automatic idx_t ring_dec(idx_t base);
        idx_t res;
        if (base == '0)
        begin
            res = LAST_IDX;
        end
        else
        begin
            res = base - idx_t'(1);
        end
        return res;
    endfunction

endpackage

@@ hdl/bdq_front.sv @@
// front stage: takes requests, decodes the opcode into a command
// depends on bdq_pkg
module bdq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bdq_pkg::req_t req,
    input  logic          cmdq_full,
    output logic          cmdq_push,
    output bdq_pkg::cmd_t cmdq_cmd
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    bdq_pkg::cmd_t hold_cmd_reg;
    bdq_pkg::cmd_t dec_cmd;
    logic          accept;

    // opcode decode
    always_comb
    begin
        dec_cmd = '0;
        dec_cmd.value = req.value;
        unique case (req.op)
            bdq_pkg::OP_PUSH_BACK:
            begin
                dec_cmd.is_push = 1'b1;
            end
            bdq_pkg::OP_PUSH_FRONT:
            begin
                dec_cmd.is_push = 1'b1;
                dec_cmd.at_front = 1'b1;
            end
            bdq_pkg::OP_VIEW:
            begin
                dec_cmd.is_view = 1'b1;
            end
            bdq_pkg::OP_POP_FRONT:
            begin
                dec_cmd.is_push = 1'b0;
            end
            default:
            begin
                dec_cmd.is_push = 1'b0;
            end
        endcase
    end

    assign req_stall = hold_valid_reg && cmdq_full;
    assign accept = req_valid && !req_stall;
    assign cmdq_push = hold_valid_reg && !cmdq_full;
    assign cmdq_cmd = hold_cmd_reg;
    assign hold_valid_next = accept || (hold_valid_reg && cmdq_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= dec_cmd;
        end
    end

endmodule

@@ hdl/bdq_cmd_fifo.sv @@
// short command queue between the front and the back
// depends on bdq_pkg
module bdq_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bdq_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output bdq_pkg::cmd_t pop_cmd,
    output logic          not_empty
);

    localparam logic [bdq_pkg::CMDQ_PTR_W-1:0] PTR_LAST =
        bdq_pkg::CMDQ_PTR_W'(bdq_pkg::CMDQ_DEPTH - 1);
    localparam logic [bdq_pkg::CMDQ_CNT_W-1:0] CNT_FULL =
        bdq_pkg::CMDQ_CNT_W'(bdq_pkg::CMDQ_DEPTH);
    localparam logic [bdq_pkg::CMDQ_CNT_W-1:0] CNT_ONE =
        bdq_pkg::CMDQ_CNT_W'(1);

    bdq_pkg::cmd_t slots [bdq_pkg::CMDQ_DEPTH];

    logic [bdq_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [bdq_pkg::CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [bdq_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [bdq_pkg::CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [bdq_pkg::CMDQ_CNT_W-1:0] count_reg;
    logic [bdq_pkg::CMDQ_CNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign pop_cmd = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/bdq_back.sv @@
// back end: ring memory, pointers, view sequencer and result register
// depends on bdq_pkg
module bdq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  bdq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdq_pkg::rsp_t rsp
);

    logic signed [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];

    bdq_pkg::back_state_t state_reg;
    bdq_pkg::back_state_t state_next;

    bdq_pkg::idx_t front_reg;
    bdq_pkg::idx_t front_next;
    bdq_pkg::cnt_t fill_reg;
    bdq_pkg::cnt_t fill_next;
    bdq_pkg::idx_t pos_reg;
    bdq_pkg::idx_t pos_next;
    bdq_pkg::cnt_t left_reg;
    bdq_pkg::cnt_t left_next;

    // read stage
    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    bdq_pkg::meta_t                    pend_meta_reg;
    logic signed [bdq_pkg::DATA_W-1:0] rdata_reg;

    // result register
    logic          out_valid_reg;
    logic          out_valid_next;
    bdq_pkg::rsp_t out_reg;

    logic           advance;
    logic           issue_ok;
    logic           take;
    logic           issue;
    bdq_pkg::meta_t issue_meta;
    logic           mem_we;
    logic           mem_re;
    bdq_pkg::idx_t  waddr;
    bdq_pkg::idx_t  raddr;

    assign advance = pend_valid_reg && (!out_valid_reg || !rsp_stall);
    assign issue_ok = !pend_valid_reg || advance;
    assign take = (state_reg == bdq_pkg::BK_IDLE) && cmd_valid && issue_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::BK_IDLE:
            begin
                if (take && !cmd.is_push && cmd.is_view && (fill_reg > bdq_pkg::cnt_t'(1)))
                begin
                    state_next = bdq_pkg::BK_VIEW;
                end
            end
            bdq_pkg::BK_VIEW:
            begin
                if (issue_ok && (left_reg == bdq_pkg::cnt_t'(1)))
                begin
                    state_next = bdq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        cmd_pop = 1'b0;
        issue = 1'b0;
        issue_meta = '0;
        issue_meta.status = bdq_pkg::ST_OK;
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr = front_reg;
        raddr = front_reg;
        front_next = front_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        left_next = left_reg;
        unique case (state_reg)
            bdq_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    cmd_pop = 1'b1;
                    issue = 1'b1;
                    issue_meta.last = 1'b1;
                    if (cmd.is_push)
                    begin
                        if (fill_reg == bdq_pkg::DEPTH_CNT)
                        begin
                            issue_meta.status = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            fill_next = fill_reg + bdq_pkg::cnt_t'(1);
                            if (cmd.at_front)
                            begin
                                waddr = bdq_pkg::ring_dec(front_reg);
                                front_next = bdq_pkg::ring_dec(front_reg);
                            end
                            else
                            begin
                                waddr = bdq_pkg::ring_add(front_reg, fill_reg);
                            end
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        issue_meta.status = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        issue_meta.use_mem = 1'b1;
                        if (cmd.is_view)
                        begin
                            issue_meta.last = (fill_reg == bdq_pkg::cnt_t'(1));
                            pos_next = bdq_pkg::ring_inc(front_reg);
                            left_next = fill_reg - bdq_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            front_next = bdq_pkg::ring_inc(front_reg);
                            fill_next = fill_reg - bdq_pkg::cnt_t'(1);
                        end
                    end
                end
            end
            bdq_pkg::BK_VIEW:
            begin
                if (issue_ok)
                begin
                    issue = 1'b1;
                    mem_re = 1'b1;
                    raddr = pos_reg;
                    issue_meta.use_mem = 1'b1;
                    issue_meta.last = (left_reg == bdq_pkg::cnt_t'(1));
                    pos_next = bdq_pkg::ring_inc(pos_reg);
                    left_next = left_reg - bdq_pkg::cnt_t'(1);
                end
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign pend_valid_next = issue || (pend_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::BK_IDLE;
            front_reg <= '0;
            fill_reg <= '0;
            pos_reg <= '0;
            left_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            fill_reg <= fill_next;
            pos_reg <= pos_next;
            left_reg <= left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring memory, one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_meta_reg <= issue_meta;
        end
        if (advance)
        begin
            out_reg.data <= pend_meta_reg.use_mem ? rdata_reg : '0;
            out_reg.status <= pend_meta_reg.status;
            out_reg.last <= pend_meta_reg.last;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

@@ hdl/bounded_deque_push_pop_view.sv @@
// top level of the bounded double-ended queue
// depends on bdq_pkg, bdq_front, bdq_cmd_fifo and bdq_back
//
// usage
//   request channel: req_valid / req_stall / req (op, value). a request is
//   taken on a rising edge with req_valid high and req_stall low.
//   op: push back, view all, pop front, push front.
//   response channel: rsp_valid / rsp_stall / rsp (data, status, last).
//   every push or pop gives one response; a view gives one response per
//   stored entry, front to back, with last set on the final one. a pop or
//   view of an empty store, or a push into a full one, gives a single
//   response carrying the empty or full status.
// timing
//   a request passes the front register, the command queue and the memory
//   read register before it reaches the response register.
//   push and pop sustain one request per cycle while rsp_stall is low;
//   a view holds the back end while its single ring read port reads each entry.
// reset
//   rst_n clears pointers, fill count and all valid flags: the store is
//   empty. ring memory contents are not cleared and need no sweep.
// backpressure
//   while rsp_stall is high the response register holds its value, the
//   read stage and the command queue fill, and then req_stall rises.
module bounded_deque_push_pop_view (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdq_pkg::rsp_t rsp
);

    // front to queue
    logic          fq_push;
    logic          fq_full;
    bdq_pkg::cmd_t fq_cmd;

    // queue to back
    logic          qb_valid;
    logic          qb_pop;
    bdq_pkg::cmd_t qb_cmd;

    // request decode and hold register
    bdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmdq_full (fq_full),
        .cmdq_push (fq_push),
        .cmdq_cmd  (fq_cmd)
    );

    // decouples request intake from the back end
    bdq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_cmd  (fq_cmd),
        .full      (fq_full),
        .pop       (qb_pop),
        .pop_cmd   (qb_cmd),
        .not_empty (qb_valid)
    );

    // ring storage, pointer update and response generation
    bdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd       (qb_cmd),
        .cmd_pop   (qb_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
